/* rtl/aqwt_pkg.sv */
// ---------------------------------------------------------------------------
// aqwt_pkg: shared types and constants of the adaptive quantum weight table
// Field widths, payload structs, table entry layout and request codes.
// ---------------------------------------------------------------------------
package aqwt_pkg;

    // Field and accumulator widths
    localparam int BASE_W  = 24;
    localparam int CLASS_W = 3;
    localparam int TICK_W  = 32;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 32;
    localparam int Q_W     = 32;
    localparam int DEN_W   = COUNT_W + TIME_W;

    // Configuration port
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    // Register index, taken from paddr[2]
    localparam logic REG_BASELINE = 1'b0;

    // Baseline quantum after reset
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1000);

    // Operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RECORD  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [CLASS_W-1:0] op_class;
        logic [TICK_W-1:0]  observed_ticks;
    } t_in;

    typedef struct packed {
        logic [Q_W-1:0] quantum;
        logic           used_baseline;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0]  time_sum;
        logic [COUNT_W-1:0] run_count;
    } t_entry;

endpackage

/* rtl/aqwt_table.sv */
// ---------------------------------------------------------------------------
// aqwt_table: per-class time and count store
// One write and one registered read per cycle; per-entry valid bits make
// an unwritten entry read as zero after reset.
// ---------------------------------------------------------------------------
module aqwt_table #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output aqwt_pkg::t_entry       o_rd_data,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  aqwt_pkg::t_entry       i_wr_data
);
    import aqwt_pkg::*;

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_entry             r_rd;
    logic               r_rd_vld;

    // Valid bits and read-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // Unwritten entries read as zero
    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

/* rtl/aqwt_mul.sv */
// ---------------------------------------------------------------------------
// aqwt_mul: bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle; product is ready when busy falls
// and holds until the next start.
// ---------------------------------------------------------------------------
module aqwt_mul #(
    parameter int A_W = 30,
    parameter int B_W = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_prod
);
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [P_W-1:0]   r_prod;
    logic [A_W-1:0]   r_mcand;
    logic [A_W:0]     sum;

    // Add the multiplicand into the top half when the low bit is set
    assign sum = {1'b0, r_prod[P_W-1:B_W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(B_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: product shifts right one bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod  <= {{A_W{1'b0}}, i_b};
            r_mcand <= i_a;
        end else if (r_busy) begin
            r_prod <= {sum, r_prod[B_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_prod;

endmodule

/* rtl/aqwt_div.sv */
// ---------------------------------------------------------------------------
// aqwt_div: restoring divider with a 32-bit quotient
// A first compare flags quotients of 2^32 or more; otherwise one quotient
// bit is produced per cycle.
// ---------------------------------------------------------------------------
module aqwt_div #(
    parameter int NUM_W = 78
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [aqwt_pkg::DEN_W-1:0] i_den,
    output logic                      o_busy,
    output logic                      o_sat,
    output logic [aqwt_pkg::Q_W-1:0]  o_quot
);
    import aqwt_pkg::*;

    localparam int STEP_W = $clog2(Q_W);

    logic              r_busy;
    logic              r_sat;
    logic [STEP_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [Q_W-1:0]    r_lo;
    logic [Q_W-1:0]    r_quot;

    logic [DEN_W-1:0]  hi_ext;
    logic              pre_sat;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  n_rem;

    // Upper numerator part decides saturation and seeds the remainder
    assign hi_ext  = DEN_W'(i_num[NUM_W-1:Q_W]);
    assign pre_sat = (hi_ext >= i_den);

    // One restoring step
    assign trial = {r_rem, r_lo[Q_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});
    assign n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sat  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !pre_sat;
            r_sat  <= pre_sat;
            r_cnt  <= STEP_W'(Q_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= hi_ext;
            r_den <= i_den;
            r_lo  <= i_num[Q_W-1:0];
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_lo   <= {r_lo[Q_W-2:0], 1'b0};
            r_quot <= {r_quot[Q_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_sat  = r_sat;
    assign o_quot = r_quot;

endmodule

/* rtl/adaptive_quantum_weight_table.sv */
// ---------------------------------------------------------------------------
// adaptive_quantum_weight_table: per-class run statistics and quantum scaling
// Records run times per operation class and answers quantum requests.
// ---------------------------------------------------------------------------
// A record request produces no result. A quantum request goes from the table
// read straight to loading the output register when the total time is zero,
// the class is empty or out of range. Otherwise it steps through, in order:
// the table read, the bit-serial multiply of baseline*NUM_CLASSES by the
// 48-bit class time (the 32-bit count times total multiply runs alongside),
// the divider start with its saturation check, the restoring divider
// (skipped when the quotient saturates), forming the quantum, loading the
// output register, which waits while the output is stalled with a result
// still held, and the return to idle. One request is in progress at a time.
// The table needs no clearing pass: per-entry valid bits are cleared by reset.
// ---------------------------------------------------------------------------
module adaptive_quantum_weight_table #(
    parameter int NUM_CLASSES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  aqwt_pkg::t_in               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output aqwt_pkg::t_out              o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aqwt_pkg::PADDR_W-1:0] paddr,
    input  logic [aqwt_pkg::APB_W-1:0]  pwdata,
    output logic [aqwt_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);
    import aqwt_pkg::*;

    localparam int IDX_W = $clog2(NUM_CLASSES);
    localparam int BN_W  = BASE_W + $clog2(NUM_CLASSES);
    localparam int NUM_W = BN_W + TIME_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [BASE_W-1:0] r_base;
    logic [TIME_W-1:0] r_total;
    t_in               r_item;
    t_out              r_res, n_res;
    t_out              r_out;
    logic              r_out_vld;

    logic              in_acc;
    logic              cfg_wr;
    logic              class_ok;
    logic              is_record;
    logic              tbl_wr;
    t_entry            ent;
    t_entry            upd;
    logic [TIME_W:0]   tsum;
    logic [TIME_W:0]   asum;
    logic [TIME_W-1:0] n_total;
    logic              mul_start;
    logic              div_start;
    logic              fin_load;
    logic [BN_W-1:0]   base_n;
    logic [NUM_W-1:0]  num_prod;
    logic [DEN_W-1:0]  den_prod;
    logic              num_busy;
    logic              den_busy;
    logic              div_busy;
    logic              div_sat;
    logic [Q_W-1:0]    div_quot;
    logic [Q_W:0]      qsum;
    logic [Q_W-1:0]    base_q;

    // Handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fin_load   = (r_state == S_FIN) && (!r_out_vld || !i_out_stall);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BASELINE);
    assign prdata = (paddr[2] == REG_BASELINE) ? APB_W'(r_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (cfg_wr) begin
            r_base <= pwdata[BASE_W-1:0];
        end
    end

    // Class table
    aqwt_table #(
        .DEPTH  (NUM_CLASSES),
        .ADDR_W (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (IDX_W'(i_in.op_class)),
        .o_rd_data (ent),
        .i_wr_en   (tbl_wr),
        .i_wr_addr (IDX_W'(r_item.op_class)),
        .i_wr_data (upd)
    );

    // Record update with saturation
    assign class_ok  = (int'(r_item.op_class) < NUM_CLASSES);
    assign is_record = (r_item.operation == OP_RECORD);
    assign tbl_wr    = (r_state == S_LOOK) && is_record && class_ok;
    assign tsum      = {1'b0, ent.time_sum} + (TIME_W + 1)'(r_item.observed_ticks);
    assign asum      = {1'b0, r_total} + (TIME_W + 1)'(r_item.observed_ticks);
    assign n_total   = asum[TIME_W] ? '1 : asum[TIME_W-1:0];

    always_comb begin
        upd.time_sum  = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
        upd.run_count = (ent.run_count == '1) ? ent.run_count : ent.run_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (tbl_wr) begin
            r_total <= n_total;
        end
    end

    // Serial products: numerator and denominator run side by side
    assign base_n    = BN_W'({{(BN_W - BASE_W){1'b0}}, r_base} * BN_W'(NUM_CLASSES));
    assign mul_start = (r_state == S_LOOK) && !is_record && (r_total != '0)
                       && class_ok && (ent.run_count != '0);

    aqwt_mul #(
        .A_W (BN_W),
        .B_W (TIME_W)
    ) u_mul_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (base_n),
        .i_b     (ent.time_sum),
        .o_busy  (num_busy),
        .o_prod  (num_prod)
    );

    aqwt_mul #(
        .A_W (TIME_W),
        .B_W (COUNT_W)
    ) u_mul_den (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_total),
        .i_b     (ent.run_count),
        .o_busy  (den_busy),
        .o_prod  (den_prod)
    );

    // Divider
    assign div_start = (r_state == S_MUL) && !num_busy && !den_busy;

    aqwt_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_prod),
        .i_den   (den_prod),
        .o_busy  (div_busy),
        .o_sat   (div_sat),
        .o_quot  (div_quot)
    );

    // Final quantum with saturation
    assign base_q = Q_W'(r_base);
    assign qsum   = (Q_W + 1)'(r_base) + (Q_W + 1)'(div_quot);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (is_record) begin
                    n_state = S_IDLE;
                end else if (r_total == '0) begin
                    n_res.quantum       = base_q;
                    n_res.used_baseline = 1'b1;
                    n_state             = S_FIN;
                end else if (mul_start) begin
                    n_state = S_MUL;
                end else begin
                    n_res.quantum       = base_q;
                    n_res.used_baseline = 1'b0;
                    n_state             = S_FIN;
                end
            end
            S_MUL: begin
                if (div_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_busy) begin
                    n_res.quantum       = (div_sat || qsum[Q_W]) ? '1 : qsum[Q_W-1:0];
                    n_res.used_baseline = 1'b0;
                    n_state             = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in;
        end
        r_res <= n_res;
        if (fin_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

/* rtl/aqwt_chk.sv */
// ---------------------------------------------------------------------------
// aqwt_chk: port-level checks for the adaptive quantum weight table
// Watches the handshakes on the top-level ports; bound to the top level.
// ---------------------------------------------------------------------------
module aqwt_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input aqwt_pkg::t_in                i_in,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input aqwt_pkg::t_out               o_out,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [aqwt_pkg::PADDR_W-1:0] paddr,
    input logic [aqwt_pkg::APB_W-1:0]   pwdata,
    input logic [aqwt_pkg::APB_W-1:0]   prdata,
    input logic                         pready
);
    import aqwt_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result changed while stalled");

    // Only one request in progress: intake closes after each accepted request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request accepted while one in progress");

    // A new result only appears while a request is being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no request in progress");

endmodule

bind adaptive_quantum_weight_table aqwt_chk u_aqwt_chk (.*);

/* tb/sv/quantum_checker.sv */
// ---------------------------------------------------------------------------
// quantum_checker: scoreboard for the adaptive quantum weight table
// Watches the request, result and register ports, keeps its own copy of the
// per-class run statistics and the baseline, predicts every quantum and
// compares each result in order against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module quantum_checker #(
    parameter int NUM_CLASSES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  aqwt_pkg::t_in                i_in,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  aqwt_pkg::t_out               i_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aqwt_pkg::PADDR_W-1:0] paddr,
    input  logic [aqwt_pkg::APB_W-1:0]   pwdata,
    input  logic                         pready,
    output int                           o_fail_count,
    output int                           o_pending
);
    import aqwt_pkg::*;

    localparam logic [TIME_W-1:0]  TIME_SAT  = '1;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
    localparam logic [63:0]        Q_MAX     = 64'hFFFF_FFFF;

    // Shadow copy of the statistics table and the baseline register
    logic [TIME_W-1:0]  class_time [NUM_CLASSES];
    logic [COUNT_W-1:0] class_runs [NUM_CLASSES];
    logic [TIME_W-1:0]  all_time;
    logic [BASE_W-1:0]  baseline;

    t_out expected_quanta [$];
    int   fail_total;

    initial begin
        fail_total = 0;
    end

    function automatic logic [TIME_W-1:0] add_time(input logic [TIME_W-1:0] acc,
                                                   input logic [TICK_W-1:0] ticks);
        logic [TIME_W:0] sum;
        sum = {1'b0, acc} + (TIME_W+1)'(ticks);
        return sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
    endfunction

    // Quantum for one class from the current statistics
    function automatic t_out predict_quantum(input logic [CLASS_W-1:0] cls);
        t_out         res;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] extra;
        logic [63:0]  q;
        res.used_baseline = (all_time == '0);
        q = 64'(baseline);
        if (!res.used_baseline && int'(cls) < NUM_CLASSES && class_runs[cls] != '0) begin
            num   = 128'(baseline) * 128'(NUM_CLASSES) * 128'(class_time[cls]);
            den   = 128'(class_runs[cls]) * 128'(all_time);
            extra = num / den;
            q = (extra > 128'(Q_MAX)) ? Q_MAX : 64'(baseline) + extra[63:0];
        end
        if (q > Q_MAX) q = Q_MAX;
        res.quantum = q[Q_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                class_time[c] = '0;
                class_runs[c] = '0;
            end
            all_time = '0;
            baseline = BASE_RESET;
            expected_quanta.delete();
        end else begin
            // Accepted request: update the table or queue a prediction
            if (i_in_valid && !i_in_stall) begin
                if (i_in.operation == OP_RECORD) begin
                    if (int'(i_in.op_class) < NUM_CLASSES) begin
                        class_time[i_in.op_class] =
                            add_time(class_time[i_in.op_class], i_in.observed_ticks);
                        if (class_runs[i_in.op_class] != COUNT_SAT)
                            class_runs[i_in.op_class]++;
                        all_time = add_time(all_time, i_in.observed_ticks);
                    end
                end else begin
                    expected_quanta.push_back(predict_quantum(i_in.op_class));
                end
            end

            // Register write
            if (psel && penable && pwrite && pready && paddr[2] == REG_BASELINE)
                baseline = pwdata[BASE_W-1:0];

            // Accepted result against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_quanta.size() == 0) begin
                    $display("%0t: unexpected result: quantum %0d used_baseline %0b",
                             $time, i_out.quantum, i_out.used_baseline);
                    fail_total++;
                end else begin
                    want = expected_quanta.pop_front();
                    if (i_out.quantum !== want.quantum) begin
                        $display("%0t: quantum mismatch: expected %0d, actual %0d",
                                 $time, want.quantum, i_out.quantum);
                        fail_total++;
                    end
                    if (i_out.used_baseline !== want.used_baseline) begin
                        $display("%0t: used_baseline mismatch: expected %0b, actual %0b",
                                 $time, want.used_baseline, i_out.used_baseline);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_quanta.size();
    end

endmodule

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb: top of the adaptive quantum weight table testbench
// Drives directed and random record and quantum requests under several
// baselines and idle/stall mixes, then loads one class with full-scale run
// times. The checker predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import aqwt_pkg::*;

    localparam int NUM_CLASSES   = 8;
    localparam int HEAVY_RUNS    = 20;
    localparam int PHASE_ITEMS   = 130;
    localparam int RECORD_SETTLE = 8;
    localparam int END_SETTLE    = 100;
    localparam logic [PADDR_W-1:0] BASELINE_ADDR = {REG_BASELINE, 2'b00};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in                i_in;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out               o_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int fail_count;
    int pending;

    adaptive_quantum_weight_table #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    quantum_checker #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_in make_item(input logic op, input int cls,
                                      input logic [TICK_W-1:0] ticks);
        t_in item;
        item.operation      = op;
        item.op_class       = CLASS_W'(cls);
        item.observed_ticks = ticks;
        return item;
    endfunction

    // Mix of zero, full-scale, small, medium and full-range run times
    function automatic logic [TICK_W-1:0] random_ticks();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) return '0;
        else if (sel < 10) return '1;
        else if (sel < 40) return TICK_W'($urandom_range(1000));
        else if (sel < 60) return TICK_W'($urandom_range(1 << 20));
        else return $urandom;
    endfunction

    // One request; valid stays high after acceptance unless the next call idles
    task automatic send_request(input t_in item);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stop sending and wait for every predicted result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Register write while idle; a record may still be finishing
    task automatic set_baseline(input logic [BASE_W-1:0] value);
        repeat (RECORD_SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASELINE_ADDR;
        pwdata  <= {8'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic request_all_classes();
        for (int c = 0; c < NUM_CLASSES; c++)
            send_request(make_item(OP_REQUEST, c, $urandom));
    endtask

    task automatic run_random_phase(input int n_items, input int idle, input int stall);
        t_in item;
        sender_idle_pct = idle;
        stall_pct       = stall;
        for (int k = 0; k < n_items; k++) begin
            item.operation      = ($urandom_range(99) < 55) ? OP_RECORD : OP_REQUEST;
            item.op_class       = CLASS_W'($urandom_range(NUM_CLASSES - 1));
            item.observed_ticks = random_ticks();
            send_request(item);
        end
        drain_results();
    endtask

    // Stimulus
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset baseline: empty table, a zero-time record,
        // full-scale record, empty class with nonzero total, every class
        send_request(make_item(OP_REQUEST, 0, $urandom));
        send_request(make_item(OP_REQUEST, NUM_CLASSES - 1, '1));
        send_request(make_item(OP_RECORD, 2, '0));
        send_request(make_item(OP_REQUEST, 2, $urandom));
        send_request(make_item(OP_RECORD, NUM_CLASSES - 1, '1));
        send_request(make_item(OP_REQUEST, NUM_CLASSES - 1, $urandom));
        send_request(make_item(OP_REQUEST, 2, $urandom));
        send_request(make_item(OP_REQUEST, 4, $urandom));
        send_request(make_item(OP_RECORD, 0, 32'd1));
        send_request(make_item(OP_RECORD, 1, 32'hAAAA_AAAA));
        send_request(make_item(OP_RECORD, 3, 32'h5555_5555));
        send_request(make_item(OP_RECORD, 4, 32'd12345));
        send_request(make_item(OP_RECORD, 5, 32'h8000_0000));
        send_request(make_item(OP_RECORD, 6, 32'd7));
        request_all_classes();
        drain_results();

        // Random phases, one baseline and idle/stall mix each
        set_baseline('0);
        run_random_phase(PHASE_ITEMS, 0, 0);
        set_baseline('1);
        run_random_phase(PHASE_ITEMS, 49, 0);
        set_baseline(BASE_W'($urandom_range(24'hFF_FFFF)));
        run_random_phase(PHASE_ITEMS, 0, 49);
        set_baseline(BASE_W'(1));
        run_random_phase(PHASE_ITEMS, 34, 34);

        // Heavy class: load one class with full-scale run times
        set_baseline(BASE_W'($urandom_range(24'hFF_FFFF)));
        sender_idle_pct = 0;
        stall_pct       = 0;
        for (int k = 0; k < HEAVY_RUNS; k++)
            send_request(make_item(OP_RECORD, 5, '1));
        sender_idle_pct = 34;
        stall_pct       = 34;
        request_all_classes();
        send_request(make_item(OP_RECORD, 5, random_ticks()));
        send_request(make_item(OP_RECORD, 6, random_ticks()));
        send_request(make_item(OP_RECORD, 1, '1));
        request_all_classes();
        drain_results();
        set_baseline('1);
        request_all_classes();
        drain_results();

        repeat (END_SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
